// ===== rtl/core/zsa_pkg.sv =====
package zsa_pkg;

	localparam int TIME_W  = 40;
	localparam int SPEND_W = 24;
	localparam int LIMIT_W = 16;
	localparam int STAT_W  = 3;
	localparam int MEAN_W  = 32;
	localparam int DEV_W   = 31;
	localparam int Z_W     = 32;
	localparam int SIZE_W  = 10;

	// shared long-division / shift-add datapath
	localparam int WIDE_W = 128;
	localparam int QUO_W  = 64;
	localparam int IT_W   = 7;
	localparam int ROOT_W = 32;

	localparam logic [STAT_W-1:0] ST_SCORED   = 3'd0;
	localparam logic [STAT_W-1:0] ST_FEW      = 3'd1;
	localparam logic [STAT_W-1:0] ST_FLAT_UP  = 3'd2;
	localparam logic [STAT_W-1:0] ST_FLAT_EQ  = 3'd3;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd4;

	typedef logic [3:0] op_t;

	localparam op_t OP_IDLE    = 4'd0;
	localparam op_t OP_MEAN_LD = 4'd1;
	localparam op_t OP_DIV     = 4'd2;
	localparam op_t OP_MEAN_SV = 4'd3;
	localparam op_t OP_MA_LD   = 4'd4;
	localparam op_t OP_MUL_ADD = 4'd5;
	localparam op_t OP_MB_LD   = 4'd6;
	localparam op_t OP_MUL_SUB = 4'd7;
	localparam op_t OP_VAR_LD  = 4'd8;
	localparam op_t OP_SQ_LD   = 4'd9;
	localparam op_t OP_SQ      = 4'd10;
	localparam op_t OP_Z_LD    = 4'd11;
	localparam op_t OP_RES     = 4'd12;

	typedef struct packed {
		logic rec_take;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic early;
		logic flat;
		logic dev_zero;
		logic it_done;
	} stat_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status_code;
		logic                     computable_flag;
		logic                     anomaly_flag;
		logic signed [SPEND_W-1:0] newest_spend;
		logic signed [MEAN_W-1:0] mean_q8;
		logic [DEV_W-1:0]         deviation_q8;
		logic signed [Z_W-1:0]    z_q16;
		logic [SIZE_W-1:0]        baseline_size;
	} res_t;

endpackage

// ===== rtl/core/zsa_if.sv =====
interface zsa_rec_if;
	logic                              valid;
	logic                              ready;
	logic [zsa_pkg::TIME_W-1:0]        record_time;
	logic signed [zsa_pkg::SPEND_W-1:0] spend_value;
	logic                              last_record;

	modport source (output valid, record_time, spend_value, last_record, input ready);
	modport sink (input valid, record_time, spend_value, last_record, output ready);
endinterface

interface zsa_res_if;
	logic                              valid;
	logic                              ready;
	logic [zsa_pkg::STAT_W-1:0]        status_code;
	logic                              computable_flag;
	logic                              anomaly_flag;
	logic signed [zsa_pkg::SPEND_W-1:0] newest_spend;
	logic signed [zsa_pkg::MEAN_W-1:0] mean_q8;
	logic [zsa_pkg::DEV_W-1:0]         deviation_q8;
	logic signed [zsa_pkg::Z_W-1:0]    z_q16;
	logic [zsa_pkg::SIZE_W-1:0]        baseline_size;

	modport source (output valid, status_code, computable_flag, anomaly_flag, newest_spend,
		mean_q8, deviation_q8, z_q16, baseline_size, input ready);
	modport sink (input valid, status_code, computable_flag, anomaly_flag, newest_spend,
		mean_q8, deviation_q8, z_q16, baseline_size, output ready);
endinterface

// ===== rtl/core/zsa_ctrl.sv =====
module zsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_last,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  zsa_pkg::stat_t stat,
	output zsa_pkg::cmd_t  cmd
);
	import zsa_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_MEAN_LD = 4'd1;
	localparam logic [3:0] S_DIV_M   = 4'd2;
	localparam logic [3:0] S_MEAN_SV = 4'd3;
	localparam logic [3:0] S_MA_LD   = 4'd4;
	localparam logic [3:0] S_MA      = 4'd5;
	localparam logic [3:0] S_MB_LD   = 4'd6;
	localparam logic [3:0] S_MB      = 4'd7;
	localparam logic [3:0] S_VAR_LD  = 4'd8;
	localparam logic [3:0] S_DIV_V   = 4'd9;
	localparam logic [3:0] S_SQ_LD   = 4'd10;
	localparam logic [3:0] S_SQ      = 4'd11;
	localparam logic [3:0] S_Z_LD    = 4'd12;
	localparam logic [3:0] S_DIV_Z   = 4'd13;
	localparam logic [3:0] S_RES     = 4'd14;

	logic [3:0] state_q, state_d;
	logic       out_full_q;
	logic       take, load;

	assign in_ready  = (state_q == S_IDLE);
	assign take      = in_valid && in_ready;
	assign out_valid = out_full_q;
	assign load      = (state_q == S_RES) && (!out_full_q || out_ready);

	always_comb begin
		state_d      = state_q;
		cmd.rec_take = take;
		cmd.op       = OP_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (take && in_last) state_d = S_MEAN_LD;
			end
			S_MEAN_LD: begin
				cmd.op  = OP_MEAN_LD;
				state_d = stat.early ? S_RES : S_DIV_M;
			end
			S_DIV_M: begin
				cmd.op = OP_DIV;
				if (stat.it_done) state_d = S_MEAN_SV;
			end
			S_MEAN_SV: begin
				cmd.op  = OP_MEAN_SV;
				state_d = S_MA_LD;
			end
			S_MA_LD: begin
				cmd.op  = OP_MA_LD;
				state_d = S_MA;
			end
			S_MA: begin
				cmd.op = OP_MUL_ADD;
				if (stat.it_done) state_d = S_MB_LD;
			end
			S_MB_LD: begin
				cmd.op  = OP_MB_LD;
				state_d = S_MB;
			end
			S_MB: begin
				cmd.op = OP_MUL_SUB;
				if (stat.it_done) state_d = S_VAR_LD;
			end
			S_VAR_LD: begin
				cmd.op  = OP_VAR_LD;
				state_d = stat.flat ? S_RES : S_DIV_V;
			end
			S_DIV_V: begin
				cmd.op = OP_DIV;
				if (stat.it_done) state_d = S_SQ_LD;
			end
			S_SQ_LD: begin
				cmd.op  = OP_SQ_LD;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op = OP_SQ;
				if (stat.it_done) state_d = S_Z_LD;
			end
			S_Z_LD: begin
				cmd.op  = OP_Z_LD;
				state_d = stat.dev_zero ? S_RES : S_DIV_Z;
			end
			S_DIV_Z: begin
				cmd.op = OP_DIV;
				if (stat.it_done) state_d = S_RES;
			end
			S_RES: begin
				if (load) begin
					cmd.op  = OP_RES;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) out_full_q <= 1'b1;
			else if (out_ready) out_full_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/zsa_dp.sv =====
module zsa_dp #(
	parameter int MAX_POINTS   = 1024,
	parameter int MIN_BASELINE = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  zsa_pkg::cmd_t                       cmd,
	output zsa_pkg::stat_t                      stat,
	input  logic [zsa_pkg::TIME_W-1:0]          record_time,
	input  logic signed [zsa_pkg::SPEND_W-1:0]  spend_value,
	input  logic [zsa_pkg::LIMIT_W-1:0]         z_limit,
	output zsa_pkg::res_t                       res
);
	import zsa_pkg::*;

	localparam int CW    = $clog2(MAX_POINTS);
	localparam int SUM_W = SPEND_W + CW;
	localparam int SQ_W  = 2 * SPEND_W - 1 + CW;
	localparam int NN_W  = 2 * CW;

	// window accumulation
	logic signed [SUM_W-1:0]   sum_q;
	logic [SQ_W-1:0]           sumsq_q;
	logic [CW-1:0]             cnt_q;
	logic [TIME_W-1:0]         top_time_q;
	logic signed [SPEND_W-1:0] top_spend_q;
	logic                      have_top_q;
	logic                      ovf_q;

	logic [CW:0]                 held;
	logic                        full;
	logic                        newer;
	logic signed [SPEND_W-1:0]   add_v;
	logic signed [2*SPEND_W-1:0] add_sq;

	// end-of-window sequencer datapath
	logic [WIDE_W-1:0]        acc_q, dvs_q;
	logic [QUO_W-1:0]         quo_q;
	logic [IT_W-1:0]          it_q;
	logic [NN_W-1:0]          nn_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic                     flat_q;
	logic [QUO_W-1:0]         sx_q, sres_q;
	logic [ROOT_W-1:0]        dev_q;
	logic                     zneg_q, nz_q;
	res_t                     res_q;

	logic [SUM_W-1:0]       mag;
	logic                   ge;
	logic [QUO_W-1:0]       sbit, strial;
	logic [MEAN_W:0]        num, nmag;
	logic signed [Z_W-1:0]  lim, zv;
	logic                   up;
	res_t                   res_d;

	assign held   = {1'b0, cnt_q} + (CW+1)'(have_top_q);
	assign full   = held >= (CW+1)'(MAX_POINTS);
	assign newer  = record_time > top_time_q;
	assign add_v  = newer ? top_spend_q : spend_value;
	assign add_sq = add_v * add_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			sumsq_q     <= '0;
			cnt_q       <= '0;
			top_time_q  <= '0;
			top_spend_q <= '0;
			have_top_q  <= 1'b0;
			ovf_q       <= 1'b0;
		end else if (cmd.op == OP_RES) begin
			sum_q       <= '0;
			sumsq_q     <= '0;
			cnt_q       <= '0;
			top_time_q  <= '0;
			top_spend_q <= '0;
			have_top_q  <= 1'b0;
			ovf_q       <= 1'b0;
		end else if (cmd.rec_take) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else if (!have_top_q) begin
				have_top_q  <= 1'b1;
				top_time_q  <= record_time;
				top_spend_q <= spend_value;
			end else begin
				// ties keep the earlier record on top
				if (newer) begin
					top_time_q  <= record_time;
					top_spend_q <= spend_value;
				end
				sum_q   <= sum_q + SUM_W'(add_v);
				sumsq_q <= sumsq_q + SQ_W'($unsigned(add_sq));
				cnt_q   <= cnt_q + 1'b1;
			end
		end
	end

	assign mag    = sum_q[SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
	assign ge     = acc_q >= dvs_q;
	assign sbit   = QUO_W'(1) << {it_q[4:0], 1'b0};
	assign strial = sres_q + sbit;
	assign num    = {top_spend_q[SPEND_W-1], top_spend_q, 8'd0} - {mean_q[MEAN_W-1], mean_q};
	assign nmag   = num[MEAN_W] ? -num : num;

	assign stat.early    = ovf_q || (int'(cnt_q) < MIN_BASELINE);
	assign stat.flat     = (acc_q == '0);
	assign stat.dev_zero = (sres_q == '0);
	assign stat.it_done  = (it_q == '0);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_MEAN_LD: begin
				// round half away from zero: (|sum|*256 + n/2) / n
				acc_q <= (WIDE_W'(mag) << 8) + WIDE_W'(cnt_q >> 1);
				dvs_q <= WIDE_W'(cnt_q) << (QUO_W - 1);
				quo_q <= '0;
				it_q  <= IT_W'(QUO_W - 1);
				nn_q  <= NN_W'(cnt_q * cnt_q);
			end
			OP_DIV: begin
				if (ge) acc_q <= acc_q - dvs_q;
				dvs_q <= dvs_q >> 1;
				quo_q <= {quo_q[QUO_W-2:0], ge};
				it_q  <= it_q - 1'b1;
			end
			OP_MEAN_SV: begin
				mean_q <= sum_q[SUM_W-1] ? -$signed(quo_q[MEAN_W-1:0])
					: $signed(quo_q[MEAN_W-1:0]);
			end
			OP_MA_LD: begin
				acc_q <= '0;
				dvs_q <= WIDE_W'(sumsq_q);
				quo_q <= QUO_W'(cnt_q);
				it_q  <= IT_W'(CW - 1);
			end
			OP_MUL_ADD: begin
				if (quo_q[0]) acc_q <= acc_q + dvs_q;
				dvs_q <= dvs_q << 1;
				quo_q <= quo_q >> 1;
				it_q  <= it_q - 1'b1;
			end
			OP_MB_LD: begin
				dvs_q <= WIDE_W'(mag);
				quo_q <= QUO_W'(mag);
				it_q  <= IT_W'(SUM_W - 1);
			end
			OP_MUL_SUB: begin
				if (quo_q[0]) acc_q <= acc_q - dvs_q;
				dvs_q <= dvs_q << 1;
				quo_q <= quo_q >> 1;
				it_q  <= it_q - 1'b1;
			end
			OP_VAR_LD: begin
				// variance Q.16 = (n*sumsq - sum^2) * 2^16 / n^2
				flat_q <= (acc_q == '0);
				acc_q  <= acc_q << 16;
				dvs_q  <= WIDE_W'(nn_q) << (QUO_W - 1);
				quo_q  <= '0;
				it_q   <= IT_W'(QUO_W - 1);
			end
			OP_SQ_LD: begin
				sx_q   <= quo_q;
				sres_q <= '0;
				it_q   <= IT_W'(QUO_W / 2 - 1);
			end
			OP_SQ: begin
				if (sx_q >= strial) begin
					sx_q   <= sx_q - strial;
					sres_q <= (sres_q >> 1) + sbit;
				end else begin
					sres_q <= sres_q >> 1;
				end
				it_q <= it_q - 1'b1;
			end
			OP_Z_LD: begin
				dev_q  <= sres_q[ROOT_W-1:0];
				zneg_q <= num[MEAN_W];
				nz_q   <= (num != '0);
				acc_q  <= WIDE_W'(nmag) << 16;
				dvs_q  <= WIDE_W'(sres_q[ROOT_W-1:0]) << (QUO_W - 1);
				quo_q  <= '0;
				it_q   <= IT_W'(QUO_W - 1);
			end
			OP_RES: begin
				res_q <= res_d;
			end
			default: begin
			end
		endcase
	end

	assign lim = {{(Z_W-LIMIT_W-8){z_limit[LIMIT_W-1]}}, z_limit, 8'd0};
	assign up  = $signed({top_spend_q, 8'd0}) > mean_q;

	always_comb begin
		if (dev_q == '0) begin
			zv = !nz_q ? '0 : (zneg_q ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}});
		end else if (!zneg_q) begin
			zv = (quo_q > QUO_W'({1'b0, {(Z_W-1){1'b1}}})) ? {1'b0, {(Z_W-1){1'b1}}}
				: $signed(quo_q[Z_W-1:0]);
		end else begin
			zv = (quo_q > QUO_W'({1'b1, {(Z_W-1){1'b0}}})) ? {1'b1, {(Z_W-1){1'b0}}}
				: -$signed(quo_q[Z_W-1:0]);
		end
	end

	always_comb begin
		res_d = '0;
		priority if (ovf_q) begin
			res_d.status_code = ST_OVERFLOW;
		end else if (int'(cnt_q) < MIN_BASELINE) begin
			res_d.status_code = ST_FEW;
		end else begin
			res_d.computable_flag = 1'b1;
			res_d.newest_spend    = top_spend_q;
			res_d.mean_q8         = mean_q;
			res_d.baseline_size   = SIZE_W'(cnt_q);
			if (flat_q) begin
				res_d.anomaly_flag = up;
				res_d.status_code  = up ? ST_FLAT_UP : ST_FLAT_EQ;
			end else begin
				res_d.status_code  = ST_SCORED;
				res_d.deviation_q8 = dev_q[DEV_W-1:0];
				res_d.z_q16        = zv;
				res_d.anomaly_flag = zv >= lim;
			end
		end
	end

	assign res = res_q;

endmodule

// ===== rtl/core/zscore_spend_anomaly.sv =====
// channel   dir  handshake      payload
// records   in   valid/ready    record_time, spend_value, last_record
// results   out  valid/ready    status_code .. baseline_size (one per window)
// cfg       in   cfg_we         cfg_wdata -> z_limit
//
// Records of a window are taken one per cycle.
// After the last record the sequencer runs the shared shift/subtract unit:
// three 64-step divides, clog2(MAX_POINTS)+SUM_W multiply steps and 32 root
// steps on a scored window (a flat baseline skips the last two divides and the root,
// zero deviation the last one), plus any wait on a full output register; records is
// held low meanwhile. Windows that fail early (overflow, too few) skip the unit.
// A result waits in its output register; records of the next window are taken
// while it waits. arst_n clears the window and sets z_limit to 3.0.
module zscore_spend_anomaly #(
	parameter int MAX_POINTS   = 1024,
	parameter int MIN_BASELINE = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [zsa_pkg::LIMIT_W-1:0] cfg_wdata,
	zsa_rec_if.sink                     records,
	zsa_res_if.source                   results
);
	import zsa_pkg::*;

	logic [LIMIT_W-1:0] z_limit_q;
	cmd_t               cmd;
	stat_t              stat;
	res_t               res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) z_limit_q <= LIMIT_W'(768);
		else if (cfg_we) z_limit_q <= cfg_wdata;
	end

	zsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (records.valid),
		.in_last   (records.last_record),
		.in_ready  (records.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	zsa_dp #(
		.MAX_POINTS   (MAX_POINTS),
		.MIN_BASELINE (MIN_BASELINE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.record_time (records.record_time),
		.spend_value (records.spend_value),
		.z_limit     (z_limit_q),
		.res         (res)
	);

	assign results.status_code     = res.status_code;
	assign results.computable_flag = res.computable_flag;
	assign results.anomaly_flag    = res.anomaly_flag;
	assign results.newest_spend    = res.newest_spend;
	assign results.mean_q8         = res.mean_q8;
	assign results.deviation_q8    = res.deviation_q8;
	assign results.z_q16           = res.z_q16;
	assign results.baseline_size   = res.baseline_size;

	a_anom_needs_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.anomaly_flag |-> results.computable_flag)
		else $error("anomaly without verdict");

	a_verdict_status: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.status_code == ST_FEW || results.status_code == ST_OVERFLOW)
		|-> !results.computable_flag && results.z_q16 == '0 && results.baseline_size == '0)
		else $error("failed window carries data");

	a_flat_no_z: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.status_code == ST_FLAT_UP || results.status_code == ST_FLAT_EQ)
		|-> results.z_q16 == '0 && results.deviation_q8 == '0)
		else $error("flat baseline with nonzero z");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && records.ready && records.last_record |=> !records.ready)
		else $error("record taken during window close");

endmodule

// ===== dv/tb_zscore_spend_anomaly.sv =====
module tb_zscore_spend_anomaly;
	import zsa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [TIME_W-1:0]  t;
		logic [SPEND_W-1:0] v;
		logic               last;
	} spend_rec_t;

	localparam int WIN_CAP   = 1024;
	localparam int MIN_BASE  = 3;
	localparam int SETTLE    = 400;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;

	zsa_rec_if records ();
	zsa_res_if results ();

	zscore_spend_anomaly dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.records(records),
		.results(results)
	);

	spend_rec_t rec_q[$];
	res_t       verdict_q[$];
	int         fails = 0;
	bit         calm = 0;
	bit         hold = 0;
	bit         took = 0;
	int         send_gap = 0;
	int         recv_gap = 0;

	// predictor state
	logic [LIMIT_W-1:0] zlim;
	longint             win_sum;
	logic [63:0]        win_sumsq;
	int                 win_count;
	logic [TIME_W-1:0]  top_t;
	longint             top_v;
	bit                 have_top;
	bit                 overflowed;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - r - b;
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic clear_window();
		win_sum = 0;
		win_sumsq = 0;
		win_count = 0;
		top_t = 0;
		top_v = 0;
		have_top = 0;
		overflowed = 0;
	endtask

	task automatic fold_record(input longint v);
		win_sum += v;
		win_sumsq += 64'(v * v);
		win_count++;
	endtask

	task automatic score_record(input spend_rec_t r);
		longint      v;
		longint      n;
		longint      mean;
		longint      num;
		longint      z;
		longint      lim;
		logic [63:0] mag;
		logic [63:0] mq;
		logic [63:0] dev;
		logic [127:0] d;
		logic [127:0] dq;
		res_t        e;
		v = longint'($signed(r.v));
		if (win_count + (have_top ? 1 : 0) >= WIN_CAP) overflowed = 1;
		else if (!have_top) begin
			have_top = 1;
			top_t = r.t;
			top_v = v;
		end else if (r.t > top_t) begin
			fold_record(top_v);
			top_t = r.t;
			top_v = v;
		end else begin
			fold_record(v);
		end
		if (!r.last) return;
		e = '0;
		if (overflowed) e.status_code = ST_OVERFLOW;
		else if (win_count < MIN_BASE) e.status_code = ST_FEW;
		else begin
			n = win_count;
			mag = win_sum < 0 ? 64'(-win_sum) : 64'(win_sum);
			mq = (mag * 256 + 64'(n / 2)) / 64'(n);
			mean = win_sum < 0 ? -longint'(mq) : longint'(mq);
			d = 128'(n) * 128'(win_sumsq) - 128'(mag) * 128'(mag);
			e.computable_flag = 1;
			e.newest_spend = top_v[SPEND_W-1:0];
			e.baseline_size = n[SIZE_W-1:0];
			e.mean_q8 = mean[MEAN_W-1:0];
			if (d == 0) begin
				e.anomaly_flag = (top_v * n > win_sum);
				e.status_code = e.anomaly_flag ? ST_FLAT_UP : ST_FLAT_EQ;
			end else begin
				dq = (d << 16) / 128'(n * n);
				dev = int_sqrt(dq[63:0]);
				e.deviation_q8 = dev[DEV_W-1:0];
				num = (top_v * 256 - mean) * 65536;
				if (dev == 0) z = num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
				else begin
					z = num / longint'(dev);
					if (z > 64'sd2147483647) z = 64'sd2147483647;
					if (z < -64'sd2147483648) z = -64'sd2147483648;
				end
				lim = longint'($signed(zlim)) * 256;
				e.anomaly_flag = z >= lim;
				e.z_q16 = z[Z_W-1:0];
				e.status_code = ST_SCORED;
			end
		end
		verdict_q.push_back(e);
		clear_window();
	endtask

	// sender
	always @(posedge clk) begin
		took = 0;
		if (arst_n && records.valid && records.ready) begin
			took = 1;
			score_record(rec_q.pop_front());
		end
	end

	always @(negedge clk) begin
		if (!arst_n) records.valid <= 1'b0;
		else if (records.valid && !took) begin
			// transaction still pending, hold it
		end else if (send_gap > 0) begin
			send_gap--;
			records.valid <= 1'b0;
		end else if (rec_q.size() > 0) begin
			if (!calm && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(1, 6) - 1;
				records.valid <= 1'b0;
			end else begin
				records.valid <= 1'b1;
				records.record_time <= rec_q[0].t;
				records.spend_value <= rec_q[0].v;
				records.last_record <= rec_q[0].last;
			end
		end else records.valid <= 1'b0;
	end

	// receiver
	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			if (verdict_q.size() == 0) begin
				fails++;
				$display("%0t: unexpected result %p", $time, res_t'{results.status_code,
					results.computable_flag, results.anomaly_flag, results.newest_spend,
					results.mean_q8, results.deviation_q8, results.z_q16,
					results.baseline_size});
			end else begin
				res_t e, g;
				e = verdict_q.pop_front();
				g = '{results.status_code, results.computable_flag, results.anomaly_flag,
					results.newest_spend, results.mean_q8, results.deviation_q8,
					results.z_q16, results.baseline_size};
				if (g !== e) begin
					fails++;
					$display("%0t: mismatch expected %p actual %p", $time, e, g);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || hold) results.ready <= 1'b0;
		else if (recv_gap > 0) begin
			recv_gap--;
			results.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			recv_gap = $urandom_range(1, 6) - 1;
			results.ready <= 1'b0;
		end else results.ready <= 1'b1;
	end

	// long receiver stall so the block backs up onto its input
	initial begin
		@(posedge arst_n);
		repeat (2000) @(posedge clk);
		hold = 1;
		repeat (2500) @(posedge clk);
		hold = 0;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [SPEND_W-1:0] pick_spend();
		case ($urandom_range(0, 3))
			0: return SPEND_W'($urandom_range(0, 40) - 20);
			1: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
			default: return SPEND_W'($urandom);
		endcase
	endfunction

	// tmode: 0 random, 1 rising, 2 all equal, 3 falling
	// smode: 0 random, 1 constant, 2 flat baseline with a higher last record, 3 extremes
	task automatic gen_window(input int len, input int tmode, input int smode);
		logic [TIME_W-1:0]  bt;
		logic [SPEND_W-1:0] c;
		spend_rec_t         r;
		bt = {$urandom, $urandom};
		c = smode == 2 ? SPEND_W'($urandom_range(0, 2000) - 1000) : pick_spend();
		for (int i = 0; i < len; i++) begin
			case (tmode)
				0: r.t = {$urandom, $urandom};
				1: r.t = bt + i;
				2: r.t = bt;
				default: r.t = bt - i;
			endcase
			case (smode)
				0: r.v = pick_spend();
				1: r.v = c;
				2: r.v = (i == len - 1) ? c + SPEND_W'($urandom_range(1, 100)) : c;
				default: r.v = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
			endcase
			r.last = (i == len - 1);
			rec_q.push_back(r);
		end
	endtask

	task automatic drain();
		while (rec_q.size() > 0 || verdict_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		zlim = val;
	endtask

	task automatic random_phase(input int n_items);
		int added;
		int len;
		added = 0;
		while (added < n_items) begin
			len = $urandom_range(0, 15) == 0 ? $urandom_range(13, 60) : $urandom_range(1, 12);
			gen_window(len, $urandom_range(0, 3), $urandom_range(0, 7) < 5 ? 0 :
				$urandom_range(1, 3));
			added += len;
		end
	endtask

	initial begin
		logic [LIMIT_W-1:0] limits[6];
		limits = '{16'h8000, 16'h7fff, 16'h0000, 16'hff00, 16'h0100, 16'h0000};
		limits[5] = LIMIT_W'($urandom);
		records.valid = 1'b0;
		records.record_time = '0;
		records.spend_value = '0;
		records.last_record = 1'b0;
		results.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		zlim = 16'd768;
		clear_window();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed windows under the reset threshold
		gen_window(1, 1, 0);
		gen_window(3, 1, 0);
		gen_window(4, 1, 2);
		gen_window(4, 2, 1);
		gen_window(4, 2, 0);
		gen_window(4, 3, 3);
		begin
			spend_rec_t r;
			r = '{40'h0, 24'h7fffff, 1'b0}; rec_q.push_back(r);
			r = '{40'hff_ffff_ffff, 24'h800000, 1'b0}; rec_q.push_back(r);
			r = '{40'h0, 24'h000000, 1'b0}; rec_q.push_back(r);
			r = '{40'hff_ffff_ffff, 24'h7fffff, 1'b1}; rec_q.push_back(r);
		end
		random_phase(200);
		drain();

		for (int p = 0; p < 6; p++) begin
			write_limit(limits[p]);
			if (p == 3) gen_window(WIN_CAP + 1, 1, 0);
			if (p == 5) calm = 1;
			random_phase(p == 5 ? 150 : 60);
			drain();
		end

		if (fails == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
